[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define OLE_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Check that a condition never holds at a rising clock edge outside reset.
`define OLE_NEVER(name, clk, rst_n, cond) \
    `OLE_ASSERT(name, clk, rst_n, !(cond))

`endif

[hdl/ole_pkg.sv]
// ----------------------------------------------------------------------------
// Ordered list engine package
// Transaction types, command and status codes, and the cell control bundle.
// ----------------------------------------------------------------------------
package ole_pkg;

    // Command kinds
    localparam logic [3:0] KIND_PUSH_BACK    = 4'd0;
    localparam logic [3:0] KIND_PUSH_FRONT   = 4'd1;
    localparam logic [3:0] KIND_POP_BACK     = 4'd2;
    localparam logic [3:0] KIND_POP_FRONT    = 4'd3;
    localparam logic [3:0] KIND_INSERT       = 4'd4;
    localparam logic [3:0] KIND_REMOVE_AT    = 4'd5;
    localparam logic [3:0] KIND_REMOVE_VALUE = 4'd6;
    localparam logic [3:0] KIND_FIND         = 4'd7;
    localparam logic [3:0] KIND_REPLACE_ALL  = 4'd8;

    // Result status codes
    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_IGNORED  = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [3:0]          kind;
        logic [4:0]          position;
        logic signed [31:0]  item_value;
        logic signed [31:0]  new_value;
    } cmd_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] found_position;
        logic [4:0] match_count;
        logic [4:0] element_count;
    } result_t;

    // Operation carried out by the cell row in the execute cycle
    typedef enum logic [2:0] {
        OP_NONE,
        OP_INSERT,
        OP_DROP,
        OP_DROP_MATCH,
        OP_FIND,
        OP_REPLACE
    } cell_op_t;

    typedef struct packed {
        logic     cmp;   // capture the compare against the probe value
        logic     exec;  // apply op this cycle
        cell_op_t op;
    } cell_ctrl_t;

endpackage

[hdl/ole_cell.sv]
// ----------------------------------------------------------------------------
// Ordered list cell
// Holds one list slot, compares it against the probe value, and shifts,
// loads or replaces its word under control of the shared command.
// ----------------------------------------------------------------------------
module ole_cell #(
    parameter int INDEX = 0,
    parameter int IW    = 4,
    parameter int CW    = 5,
    parameter int DW    = 32
) (
    input  logic               clk,
    input  ole_pkg::cell_ctrl_t ctrl,
    input  logic [CW-1:0]      occ,
    input  logic [IW-1:0]      pos,
    input  logic [DW-1:0]      probe,
    input  logic [DW-1:0]      load_val,
    input  logic [DW-1:0]      repl_val,
    input  logic [DW-1:0]      left_data,
    input  logic [DW-1:0]      right_data,
    input  logic               seen_in,
    output logic [DW-1:0]      data,
    output logic               seen_out,
    output logic               match,
    output logic [IW-1:0]      first_idx
);

    logic [DW-1:0] data_reg;
    logic [DW-1:0] data_next;
    logic          match_reg;
    logic          match_next;
    logic          hit;
    logic          pos_op;

    assign pos_op = (ctrl.op == ole_pkg::OP_INSERT) || (ctrl.op == ole_pkg::OP_DROP);
    assign hit    = pos_op ? (IW'(INDEX) == pos) : match_reg;

    assign seen_out  = seen_in | hit;
    assign first_idx = (hit && !seen_in) ? IW'(INDEX) : '0;
    assign data      = data_reg;
    assign match     = match_reg;

    // Only slots below the occupancy take part in a match
    assign match_next = ctrl.cmp ? ((data_reg == probe) && (CW'(INDEX) < occ)) : match_reg;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.exec)
        begin
            unique case (ctrl.op)
                ole_pkg::OP_INSERT:
                begin
                    if (hit)
                        data_next = load_val;
                    else if (seen_in)
                        data_next = left_data;
                end
                ole_pkg::OP_DROP,
                ole_pkg::OP_DROP_MATCH:
                begin
                    if (seen_out)
                        data_next = right_data;
                end
                ole_pkg::OP_REPLACE:
                begin
                    if (match_reg)
                        data_next = repl_val;
                end
                default:
                begin
                    data_next = data_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg  <= data_next;
        match_reg <= match_next;
    end

endmodule

[hdl/ordered_list_engine_top.sv]
// ----------------------------------------------------------------------------
// Ordered list engine
// Bounded ordered list of signed words held in a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   A command transaction is taken at a rising edge with start high and busy
//   low. The command's value is compared against every cell at that edge.
//   busy then stays high for one execute cycle, in which the cells shift,
//   load or replace in parallel and the first-match chain ripples from cell
//   to cell. One result per command appears on result with done high for
//   exactly one cycle; done and result are registered from the execute cycle.
//   No new command is taken while busy is high; the compare cycle is followed
//   by the execute cycle through the cell row. busy is low while the result
//   is shown, so the next command can be taken then.
//   The receiver cannot stall: a result not taken in its cycle is gone.
//   Reset empties the list and clears busy and done; slot contents are left
//   as they are, since only slots below the element count are ever read.
// ----------------------------------------------------------------------------
module ordered_list_engine_top #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  ole_pkg::cmd_t    cmd,
    output logic             busy,
    output logic             done,
    output ole_pkg::result_t result
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > 5) ? CW : 5;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t              state_reg, state_next;
    ole_pkg::cell_op_t   op_reg, op_next;
    logic [IW-1:0]       pos_reg, pos_next;
    logic [DATA_WIDTH-1:0] val_reg, nval_reg;
    logic [1:0]          status_reg, status_next;
    logic [CW-1:0]       occ_reg, occ_next;
    logic                done_reg;
    ole_pkg::result_t    result_reg, result_next;

    logic                accept;
    logic [63:0]         val64, nval64;
    logic [DATA_WIDTH-1:0] val_ext, nval_ext;
    logic [PW-1:0]       pos_ext, occ_ext;
    logic                full, empty;
    logic [CW-1:0]       occ_m1;
    ole_pkg::cell_ctrl_t ctrl;

    logic [DEPTH:0]                      seen;
    logic [DEPTH-1:0][DATA_WIDTH-1:0]    cell_data;
    logic [DEPTH-1:0]                    match_vec;
    logic [DEPTH-1:0][IW-1:0]            first_vec;
    logic [IW-1:0]                       first_pos;
    logic [CW-1:0]                       match_cnt;
    logic                                found;
    logic [1:0]                          status_fin;
    logic [31:0]                         occ_wide, pos_wide, cnt_wide;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg == S_EXEC);
    assign done   = done_reg;
    assign result = result_reg;

    // Reduce the incoming words to the stored width
    assign val64    = {32'd0, cmd.item_value};
    assign nval64   = {32'd0, cmd.new_value};
    assign val_ext  = val64[DATA_WIDTH-1:0];
    assign nval_ext = nval64[DATA_WIDTH-1:0];

    assign pos_ext = PW'(cmd.position);
    assign occ_ext = PW'(occ_reg);
    assign full    = (occ_reg == CW'(DEPTH));
    assign empty   = (occ_reg == '0);
    assign occ_m1  = occ_reg - 1'b1;

    // Decode: index and capacity checks are settled when the command is taken
    always_comb
    begin
        op_next     = ole_pkg::OP_NONE;
        pos_next    = '0;
        status_next = ole_pkg::ST_DONE;
        unique case (cmd.kind)
            ole_pkg::KIND_PUSH_BACK:
            begin
                if (full)
                    status_next = ole_pkg::ST_FULL;
                else
                begin
                    op_next  = ole_pkg::OP_INSERT;
                    pos_next = occ_reg[IW-1:0];
                end
            end
            ole_pkg::KIND_PUSH_FRONT:
            begin
                if (full)
                    status_next = ole_pkg::ST_FULL;
                else
                    op_next = ole_pkg::OP_INSERT;
            end
            ole_pkg::KIND_POP_BACK:
            begin
                if (empty)
                    status_next = ole_pkg::ST_IGNORED;
                else
                begin
                    op_next  = ole_pkg::OP_DROP;
                    pos_next = occ_m1[IW-1:0];
                end
            end
            ole_pkg::KIND_POP_FRONT:
            begin
                if (empty)
                    status_next = ole_pkg::ST_IGNORED;
                else
                    op_next = ole_pkg::OP_DROP;
            end
            ole_pkg::KIND_INSERT:
            begin
                if (pos_ext > occ_ext)
                    status_next = ole_pkg::ST_IGNORED;
                else if (full)
                    status_next = ole_pkg::ST_FULL;
                else
                begin
                    op_next  = ole_pkg::OP_INSERT;
                    pos_next = pos_ext[IW-1:0];
                end
            end
            ole_pkg::KIND_REMOVE_AT:
            begin
                if (pos_ext >= occ_ext)
                    status_next = ole_pkg::ST_IGNORED;
                else
                begin
                    op_next  = ole_pkg::OP_DROP;
                    pos_next = pos_ext[IW-1:0];
                end
            end
            ole_pkg::KIND_REMOVE_VALUE: op_next = ole_pkg::OP_DROP_MATCH;
            ole_pkg::KIND_FIND:         op_next = ole_pkg::OP_FIND;
            ole_pkg::KIND_REPLACE_ALL:  op_next = ole_pkg::OP_REPLACE;
            default:                    status_next = ole_pkg::ST_IGNORED;
        endcase
    end

    assign ctrl.cmp  = accept;
    assign ctrl.exec = (state_reg == S_EXEC);
    assign ctrl.op   = op_reg;

    assign seen[0] = 1'b0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_d, right_d;

        if (i == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_d = cell_data[i];
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[i+1];
        end

        ole_cell #(
            .INDEX (i),
            .IW    (IW),
            .CW    (CW),
            .DW    (DATA_WIDTH)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .occ        (occ_reg),
            .pos        (pos_reg),
            .probe      (val_ext),
            .load_val   (val_reg),
            .repl_val   (nval_reg),
            .left_data  (left_d),
            .right_data (right_d),
            .seen_in    (seen[i]),
            .data       (cell_data[i]),
            .seen_out   (seen[i+1]),
            .match      (match_vec[i]),
            .first_idx  (first_vec[i])
        );
    end

    // At most one cell reports a first match, so OR its index out
    always_comb
    begin
        first_pos = '0;
        for (int i = 0; i < DEPTH; i++)
            first_pos = first_pos | first_vec[i];
    end

    assign match_cnt = CW'($countones(match_vec));
    assign found     = seen[DEPTH];

    // Finish the command in the execute cycle
    always_comb
    begin
        occ_next   = occ_reg;
        status_fin = status_reg;
        pos_wide   = 32'd0;
        cnt_wide   = 32'd0;
        unique case (op_reg)
            ole_pkg::OP_INSERT: occ_next = occ_reg + 1'b1;
            ole_pkg::OP_DROP:   occ_next = occ_m1;
            ole_pkg::OP_DROP_MATCH:
            begin
                if (found)
                    occ_next = occ_m1;
                else
                    status_fin = ole_pkg::ST_NOTFOUND;
            end
            ole_pkg::OP_FIND:
            begin
                if (found)
                    pos_wide = 32'(first_pos);
                else
                    status_fin = ole_pkg::ST_NOTFOUND;
            end
            ole_pkg::OP_REPLACE:
            begin
                cnt_wide = 32'(match_cnt);
                if (!found)
                    status_fin = ole_pkg::ST_NOTFOUND;
            end
            default:
            begin
                occ_next = occ_reg;
            end
        endcase
        occ_wide = 32'(occ_next);
        result_next.status         = status_fin;
        result_next.found_position = pos_wide[3:0];
        result_next.match_count    = cnt_wide[4:0];
        result_next.element_count  = occ_wide[4:0];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (start) state_next = S_EXEC;
            S_EXEC:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            occ_reg   <= '0;
            done_reg  <= 1'b0;
            op_reg    <= ole_pkg::OP_NONE;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_EXEC);
            if (state_reg == S_EXEC)
                occ_reg <= occ_next;
            if (accept)
                op_reg <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pos_reg    <= pos_next;
            val_reg    <= val_ext;
            nval_reg   <= nval_ext;
            status_reg <= status_next;
        end
        if (state_reg == S_EXEC)
            result_reg <= result_next;
    end

endmodule

[hdl/ole_checker.sv]
// ----------------------------------------------------------------------------
// Ordered list engine checker
// Port-level checks on command/result timing and result field consistency.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ole_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             done,
    input ole_pkg::result_t result
);

    `OLE_ASSERT(a_accept_busy, clk, rst_n, (start && !busy) |=> busy)
    `OLE_ASSERT(a_busy_done, clk, rst_n, busy |=> (done && !busy))
    `OLE_ASSERT(a_done_after_busy, clk, rst_n, done |-> $past(busy))
    `OLE_NEVER(a_fail_fields, clk, rst_n,
        done && (result.status != ole_pkg::ST_DONE)
            && ((result.match_count != 5'd0) || (result.found_position != 4'd0)))

endmodule

bind ordered_list_engine_top ole_checker u_ole_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

[dv/tb_ordered_list_engine_top.sv]
// ----------------------------------------------------------------------------
// Ordered list engine testbench
// Drives command transactions into the list engine and keeps a shadow list to
// work out each result. A short table covers the empty list, extreme values,
// every command and the ignored cases. Random segments then fill, drain or mix
// the list, using small value pools so that matches are common.
// ----------------------------------------------------------------------------
module tb_ordered_list_engine_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = 16;
    localparam int RANDOM_ITEMS = 1700;
    localparam int LIMIT_CYCLES = 400000;

    localparam logic [3:0]  KIND_UNKNOWN_LO = 4'd9;
    localparam logic [3:0]  KIND_UNKNOWN_HI = 4'd15;
    localparam logic [31:0] WORD_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] WORD_MIN  = 32'h8000_0000;
    localparam logic [31:0] WORD_ONES = 32'hFFFF_FFFF;

    typedef enum {SEG_FILL, SEG_DRAIN, SEG_MIX} seg_kind_t;

    typedef struct {
        ole_pkg::cmd_t    c;
        bit               typed;
        ole_pkg::result_t r;
    } dir_row_t;

    logic             clk;
    logic             rst_n;
    logic             start;
    ole_pkg::cmd_t    cmd;
    logic             busy;
    logic             done;
    ole_pkg::result_t result;

    logic [31:0]      list_words[$];
    ole_pkg::result_t expected_results[$];
    dir_row_t         dir_rows[$];
    logic [31:0]      value_pool[4];
    int               pool_size;
    int               err_count = 0;
    int               cycle_count = 0;
    bit               no_idle;

    ordered_list_engine_top #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (32)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Shadow list: apply one command and return the result it must produce.
    function automatic ole_pkg::result_t apply_to_list(ole_pkg::cmd_t c);
        ole_pkg::result_t res;
        int               hit;
        int               n;
        res = '0;
        res.status = ole_pkg::ST_DONE;
        hit = -1;
        n = 0;
        case (c.kind)
            ole_pkg::KIND_PUSH_BACK, ole_pkg::KIND_PUSH_FRONT:
                if (list_words.size() >= DEPTH)
                    res.status = ole_pkg::ST_FULL;
                else if (c.kind == ole_pkg::KIND_PUSH_BACK)
                    list_words.insert(list_words.size(), c.item_value);
                else
                    list_words.insert(0, c.item_value);
            ole_pkg::KIND_POP_BACK, ole_pkg::KIND_POP_FRONT:
                if (list_words.size() == 0)
                    res.status = ole_pkg::ST_IGNORED;
                else if (c.kind == ole_pkg::KIND_POP_BACK)
                    list_words.delete(list_words.size() - 1);
                else
                    list_words.delete(0);
            ole_pkg::KIND_INSERT:
                // a bad position wins over a full list
                if (int'(c.position) > list_words.size())
                    res.status = ole_pkg::ST_IGNORED;
                else if (list_words.size() >= DEPTH)
                    res.status = ole_pkg::ST_FULL;
                else
                    list_words.insert(int'(c.position), c.item_value);
            ole_pkg::KIND_REMOVE_AT:
                if (int'(c.position) >= list_words.size())
                    res.status = ole_pkg::ST_IGNORED;
                else
                    list_words.delete(int'(c.position));
            ole_pkg::KIND_REMOVE_VALUE, ole_pkg::KIND_FIND:
            begin
                foreach (list_words[i])
                    if (hit < 0 && list_words[i] == c.item_value)
                        hit = i;
                if (hit < 0)
                    res.status = ole_pkg::ST_NOTFOUND;
                else if (c.kind == ole_pkg::KIND_REMOVE_VALUE)
                    list_words.delete(hit);
                else
                    res.found_position = 4'(hit);
            end
            ole_pkg::KIND_REPLACE_ALL:
            begin
                foreach (list_words[i])
                    if (list_words[i] == c.item_value)
                    begin
                        list_words[i] = c.new_value;
                        n++;
                    end
                if (n == 0)
                    res.status = ole_pkg::ST_NOTFOUND;
                res.match_count = 5'(n);
            end
            default:
                res.status = ole_pkg::ST_IGNORED;
        endcase
        res.element_count = 5'(list_words.size());
        return res;
    endfunction

    function automatic dir_row_t row(logic [3:0] k, int p, logic [31:0] v,
                                     logic [31:0] nv, bit typed, logic [1:0] st,
                                     int ec);
        dir_row_t d;
        d.c.kind           = k;
        d.c.position       = 5'(p);
        d.c.item_value     = v;
        d.c.new_value      = nv;
        d.typed            = typed;
        d.r                = '0;
        d.r.status         = st;
        d.r.element_count  = 5'(ec);
        return d;
    endfunction

    function automatic void add_row(dir_row_t d);
        dir_rows.insert(dir_rows.size(), d);
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [31:0] pick_value();
        if ($urandom_range(0, 4) == 0)
            return $urandom;
        return value_pool[$urandom_range(0, pool_size - 1)];
    endfunction

    function automatic ole_pkg::cmd_t random_cmd(seg_kind_t mode);
        ole_pkg::cmd_t c;
        int            r;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 24) == 0)
            c.kind = 4'($urandom_range(int'(KIND_UNKNOWN_LO), int'(KIND_UNKNOWN_HI)));
        else
            c.kind = 4'($urandom_range(0, int'(ole_pkg::KIND_REPLACE_ALL)));
        if (mode == SEG_FILL)
        begin
            if (r < 25)
                c.kind = ole_pkg::KIND_PUSH_BACK;
            else if (r < 45)
                c.kind = ole_pkg::KIND_PUSH_FRONT;
            else if (r < 70)
                c.kind = ole_pkg::KIND_INSERT;
        end
        else if (mode == SEG_DRAIN)
        begin
            if (r < 20)
                c.kind = ole_pkg::KIND_POP_BACK;
            else if (r < 40)
                c.kind = ole_pkg::KIND_POP_FRONT;
            else if (r < 55)
                c.kind = ole_pkg::KIND_REMOVE_AT;
            else if (r < 70)
                c.kind = ole_pkg::KIND_REMOVE_VALUE;
        end
        if ($urandom_range(0, 3) == 0)
            c.position = 5'($urandom_range(0, 31));
        else
            c.position = 5'($urandom_range(0, list_words.size()));
        c.item_value = pick_value();
        c.new_value  = pick_value();
        return c;
    endfunction

    // Hold the command until it is taken, then log what it must return.
    task automatic issue_cmd(input ole_pkg::cmd_t c, input bit typed,
                             input ole_pkg::result_t want);
        ole_pkg::result_t predicted;
        int               gap;
        cmd   <= c;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        predicted = apply_to_list(c);
        expected_results.insert(expected_results.size(), typed ? want : predicted);
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop start and hold until every outstanding result has come back.
    task automatic settle();
        start <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
    endtask

    always @(posedge clk)
    begin : result_check
        ole_pkg::result_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                err_count++;
                $display("%0t: unexpected result: expected none, actual %p", $time, result);
            end
            else
            begin
                want = expected_results[0];
                expected_results.delete(0);
                if (result !== want)
                begin
                    err_count++;
                    $display("%0t: mismatch: expected status %0d pos %0d matches %0d count %0d",
                             $time, want.status, want.found_position, want.match_count,
                             want.element_count);
                    $display("%0t:           actual status %0d pos %0d matches %0d count %0d",
                             $time, result.status, result.found_position, result.match_count,
                             result.element_count);
                end
            end
        end
    end

    initial
    begin : stimulus
        seg_kind_t mode;
        int        sent;
        int        seg_len;
        rst_n = 1'b0;
        start = 1'b0;
        cmd   = '0;

        // empty list
        add_row(row(ole_pkg::KIND_POP_BACK,     0, 0, 0, 1'b1, ole_pkg::ST_IGNORED,  0));
        add_row(row(ole_pkg::KIND_POP_FRONT,    0, 0, 0, 1'b1, ole_pkg::ST_IGNORED,  0));
        add_row(row(ole_pkg::KIND_REMOVE_AT,    0, 0, 0, 1'b1, ole_pkg::ST_IGNORED,  0));
        add_row(row(ole_pkg::KIND_FIND,         0, 0, 0, 1'b1, ole_pkg::ST_NOTFOUND, 0));
        add_row(row(ole_pkg::KIND_REPLACE_ALL,  0, 0, 1, 1'b1, ole_pkg::ST_NOTFOUND, 0));
        add_row(row(ole_pkg::KIND_REMOVE_VALUE, 0, 0, 0, 1'b1, ole_pkg::ST_NOTFOUND, 0));
        add_row(row(ole_pkg::KIND_INSERT,       1, 7, 0, 1'b1, ole_pkg::ST_IGNORED,  0));
        // extremes going in
        add_row(row(ole_pkg::KIND_INSERT,     0, WORD_MAX,  0, 1'b1, ole_pkg::ST_DONE, 1));
        add_row(row(ole_pkg::KIND_PUSH_BACK,  0, WORD_MIN,  0, 1'b1, ole_pkg::ST_DONE, 2));
        add_row(row(ole_pkg::KIND_PUSH_FRONT, 0, WORD_ONES, 0, 1'b1, ole_pkg::ST_DONE, 3));
        add_row(row(ole_pkg::KIND_PUSH_BACK,  0, 0,         0, 1'b1, ole_pkg::ST_DONE, 4));
        // searches, replacements, removals, an insert and unknown kinds
        add_row(row(ole_pkg::KIND_FIND,         0,  WORD_MIN,  0,         1'b0,
                    ole_pkg::ST_DONE, 0));
        add_row(row(ole_pkg::KIND_FIND,         0,  0,         0,         1'b0,
                    ole_pkg::ST_DONE, 0));
        add_row(row(ole_pkg::KIND_REPLACE_ALL,  0,  WORD_MAX,  0,         1'b0,
                    ole_pkg::ST_DONE, 0));
        add_row(row(ole_pkg::KIND_REPLACE_ALL,  0,  0,         WORD_MIN,  1'b0,
                    ole_pkg::ST_DONE, 0));
        add_row(row(ole_pkg::KIND_REMOVE_VALUE, 0,  WORD_MIN,  0,         1'b0,
                    ole_pkg::ST_DONE, 0));
        add_row(row(ole_pkg::KIND_REMOVE_VALUE, 0,  32'd123,   0,         1'b0,
                    ole_pkg::ST_DONE, 0));
        add_row(row(ole_pkg::KIND_REMOVE_AT,    31, 0,         0,         1'b0,
                    ole_pkg::ST_DONE, 0));
        add_row(row(ole_pkg::KIND_REMOVE_AT,    1,  0,         0,         1'b0,
                    ole_pkg::ST_DONE, 0));
        add_row(row(ole_pkg::KIND_INSERT,       2,  32'd5,     0,         1'b0,
                    ole_pkg::ST_DONE, 0));
        add_row(row(KIND_UNKNOWN_LO,            0,  0,         0,         1'b0,
                    ole_pkg::ST_DONE, 0));
        add_row(row(KIND_UNKNOWN_HI,            31, WORD_ONES, WORD_ONES, 1'b0,
                    ole_pkg::ST_DONE, 0));
        add_row(row(ole_pkg::KIND_POP_BACK,     0,  0,         0,         1'b0,
                    ole_pkg::ST_DONE, 0));
        add_row(row(ole_pkg::KIND_POP_FRONT,    0,  0,         0,         1'b0,
                    ole_pkg::ST_DONE, 0));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        no_idle = 1'b0;
        foreach (dir_rows[i])
            issue_cmd(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].r);
        settle();

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            mode      = seg_kind_t'($urandom_range(0, 2));
            no_idle   = ($urandom_range(0, 4) == 0);
            seg_len   = $urandom_range(10, 60);
            // a pool of one value lets a full list match everywhere
            pool_size = $urandom_range(1, 4);
            foreach (value_pool[i])
                case ($urandom_range(0, 5))
                    0: value_pool[i] = '0;
                    1: value_pool[i] = WORD_MAX;
                    2: value_pool[i] = WORD_MIN;
                    3: value_pool[i] = WORD_ONES;
                    default: value_pool[i] = $urandom;
                endcase
            repeat (seg_len)
            begin
                issue_cmd(random_cmd(mode), 1'b0, '0);
                sent++;
            end
            if ($urandom_range(0, 5) == 0)
                settle();
        end

        settle();
        repeat (4) @(posedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[sim.f]
+incdir+hdl
hdl/ole_pkg.sv
hdl/ole_cell.sv
hdl/ordered_list_engine_top.sv
hdl/ole_checker.sv
dv/tb_ordered_list_engine_top.sv
